>>> rtl/vce_pkg.sv
// Shared types, constants and helpers of the vertex coreness estimator.
package vce_pkg;

   localparam int unsigned CORE_W     = 8;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned HIST_DEPTH = 256;
   localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
   localparam int unsigned SUP_W      = CNT_W + HIST_AW;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 8;

   localparam longint unsigned MAX_CORENESS  = 255;
   localparam longint unsigned MAX_NEIGHBORS = 65535;

   localparam longint unsigned EST_LIMIT_L =
      (MAX_CORENESS > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : MAX_CORENESS;
   localparam longint unsigned CNT_MAX_L = (64'd1 << CNT_W) - 1;
   localparam longint unsigned COUNT_CAP_L =
      (MAX_NEIGHBORS < CNT_MAX_L) ? MAX_NEIGHBORS : CNT_MAX_L;

   localparam logic [CORE_W-1:0] EST_LIMIT = CORE_W'(EST_LIMIT_L);
   localparam logic [CNT_W-1:0]  COUNT_CAP = CNT_W'(COUNT_CAP_L);

   // Histogram port request from the sequencer.
   typedef struct packed {
      logic               clear;
      logic [HIST_AW-1:0] rd_addr;
      logic               wr_en;
      logic [HIST_AW-1:0] wr_addr;
      logic [CNT_W-1:0]   wr_data;
   } hist_req_type;

   function automatic logic [CORE_W-1:0] clip_est(input logic [CORE_W-1:0] v);
      clip_est = (v > EST_LIMIT) ? EST_LIMIT : v;
   endfunction

endpackage

>>> rtl/vertex_coreness_estimator_unit.sv
// Top level of the vertex coreness estimator: sequencer around the histogram.
//
//  port group | dir | fields (low bit up)
//  req_*      | in  | tdata: new_estimate, old_estimate; tuser: first_round, has_message;
//             |     | tlast: end_of_round
//  rsp_*      | out | tdata: coreness; tuser: changed
//  csr_*      | in  | wr_data: initial_coreness
//
// One word in flight at a time; the histogram RAM port (one read + one write a
// cycle) sets the pace. A word steps through S_DEC for a moved count, S_INC for
// a counted message and S_WALK for a round-end walk, one slot per step, then S_DONE.
// A word is taken while the previous result still sits in the output register.
// Reset and a CSR write clear the histogram at once (valid bits), no sweep.
module vertex_coreness_estimator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [vce_pkg::CORE_W-1:0]       csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vce_pkg::REQ_DATA_W-1:0]   req_tdata,  // new_estimate, old_estimate
   input  logic [vce_pkg::REQ_USER_W-1:0]   req_tuser,  // first_round, has_message
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [vce_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // coreness
   output logic                             rsp_tuser   // changed
);
   import vce_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC,
      S_INC,
      S_WALK,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CORE_W-1:0]   est_ff, est_in;
   logic                pending_ff, pending_in;
   logic                walk_ff, walk_in;
   logic                changed_ff, changed_in;
   logic [HIST_AW-1:0]  dec_addr_ff, dec_addr_in;
   logic [HIST_AW-1:0]  inc_addr_ff, inc_addr_in;
   logic [HIST_AW-1:0]  cur_ff, cur_in;
   logic [SUP_W-1:0]    support_ff, support_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CORE_W-1:0]   rsp_core_ff, rsp_core_in;
   logic                rsp_chg_ff, rsp_chg_in;

   hist_req_type        hreq;
   logic [CNT_W-1:0]    hist_q;

   logic                accept;
   logic [CORE_W-1:0]   nv, ov;
   logic                first, msg, eor;
   logic                lower, do_dec, do_inc, pend_new, walk_new;
   logic [SUP_W-1:0]    sum;

   vce_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .req     (hreq),
      .rd_data (hist_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign nv    = req_tdata[CORE_W-1:0];
   assign ov    = req_tdata[2*CORE_W-1:CORE_W];
   assign first = req_tuser[0];
   assign msg   = req_tuser[1];
   assign eor   = req_tlast;

   assign lower    = nv < est_ff;
   assign do_dec   = msg && !first && lower;
   assign do_inc   = msg && (first || lower);
   assign pend_new = pending_ff || first || do_dec;
   assign walk_new = eor && pend_new;
   assign sum      = support_ff + SUP_W'(hist_q);

   always_comb begin
      state_in     = state_ff;
      est_in       = est_ff;
      pending_in   = pending_ff;
      walk_in      = walk_ff;
      changed_in   = changed_ff;
      dec_addr_in  = dec_addr_ff;
      inc_addr_in  = inc_addr_ff;
      cur_in       = cur_ff;
      support_in   = support_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_core_in  = rsp_core_ff;
      rsp_chg_in   = rsp_chg_ff;

      hreq.clear   = csr_wr_en;
      hreq.rd_addr = cur_ff;
      hreq.wr_en   = 1'b0;
      hreq.wr_addr = cur_ff;
      hreq.wr_data = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               changed_in  = 1'b0;
               pending_in  = pend_new;
               walk_in     = walk_new;
               dec_addr_in = (ov < est_ff) ? ov : est_ff;
               inc_addr_in = (first && !lower) ? est_ff : nv;
               support_in  = '0;
               if (do_dec) begin
                  hreq.rd_addr = (ov < est_ff) ? ov : est_ff;
                  state_in     = S_DEC;
               end else if (do_inc) begin
                  hreq.rd_addr = (first && !lower) ? est_ff : nv;
                  state_in     = S_INC;
               end else if (walk_new) begin
                  hreq.rd_addr = est_ff;
                  cur_in       = est_ff;
                  state_in     = S_WALK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DEC: begin
            hreq.wr_en   = 1'b1;
            hreq.wr_addr = dec_addr_ff;
            hreq.wr_data = (hist_q != '0) ? hist_q - CNT_W'(1) : hist_q;
            hreq.rd_addr = inc_addr_ff;
            state_in     = S_INC;
         end
         S_INC: begin
            hreq.wr_en   = 1'b1;
            hreq.wr_addr = inc_addr_ff;
            hreq.wr_data = (hist_q < COUNT_CAP) ? hist_q + CNT_W'(1) : hist_q;
            if (walk_ff) begin
               hreq.rd_addr = est_ff;
               cur_in       = est_ff;
               support_in   = '0;
               state_in     = S_WALK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WALK: begin
            // hist_q is the slot at cur_ff; one slot per cycle downward
            if (sum >= SUP_W'(cur_ff)) begin
               hreq.wr_en   = 1'b1;
               hreq.wr_addr = cur_ff;
               hreq.wr_data = (sum > SUP_W'(COUNT_CAP)) ? COUNT_CAP : sum[CNT_W-1:0];
               est_in       = cur_ff;
               changed_in   = (cur_ff != est_ff);
               pending_in   = 1'b0;
               state_in     = S_DONE;
            end else begin
               hreq.rd_addr = cur_ff - HIST_AW'(1);
               cur_in       = cur_ff - HIST_AW'(1);
               support_in   = sum;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_core_in  = est_ff;
               rsp_chg_in   = changed_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         est_in     = clip_est(csr_wr_data);
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         est_ff       <= '0;
         pending_ff   <= 1'b0;
         walk_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         pending_ff   <= pending_in;
         walk_ff      <= walk_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dec_addr_ff <= dec_addr_in;
      inc_addr_ff <= inc_addr_in;
      cur_ff      <= cur_in;
      support_ff  <= support_in;
      rsp_core_ff <= rsp_core_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_core_ff);
   assign rsp_tuser  = rsp_chg_ff;

   // estimate only moves down between CSR writes
   a_est_monotone: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en |=> (est_ff <= $past(est_ff)))
      else $error("estimate rose without a CSR write");

   a_est_limit: assert property (@(posedge clock) disable iff (reset)
      est_ff <= EST_LIMIT)
      else $error("estimate above limit");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      hreq.wr_en |-> (hreq.wr_data <= COUNT_CAP))
      else $error("histogram count above cap");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second word taken while one is in flight");

   a_changed_lower: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && state_in == S_DONE && changed_in) |=>
         (est_ff < $past(est_ff)))
      else $error("changed flagged without a lower estimate");

endmodule

>>> rtl/vce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module vce_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/vce_hist.sv
// Neighbor histogram: RAM plus per-slot valid bits and write-to-read forwarding.
module vce_hist (
   input  logic                        clock,
   input  logic                        reset,
   input  vce_pkg::hist_req_type       req,
   output logic [vce_pkg::CNT_W-1:0]   rd_data
);
   import vce_pkg::*;

   logic [CNT_W-1:0]      ram_q;
   logic [HIST_DEPTH-1:0] valid_ff;
   logic                  valid_rd_ff;
   logic                  fwd_hit_ff;
   logic [CNT_W-1:0]      fwd_data_ff;

   vce_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_addr (req.rd_addr),
      .rd_data (ram_q)
   );

   // Never-written slots read as zero; clear drops them all at once.
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff   <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         fwd_hit_ff <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
      valid_rd_ff <= valid_ff[req.rd_addr];
      fwd_data_ff <= req.wr_data;
   end

   // RAM returns old data on a same-cycle write; take the new word instead.
   assign rd_data = fwd_hit_ff  ? fwd_data_ff :
                    valid_rd_ff ? ram_q       : '0;

endmodule
